/* sv/arud_pkg.sv */
// Shared types, constants and the seven-segment decode for the up/down counter display.
`default_nettype none
package arud_pkg;

    localparam int COUNT_W    = 10;
    localparam int INTERVAL_W = 16;
    localparam int SEG_W      = 7;
    localparam int SEL_W      = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 16'd500;
    localparam logic [COUNT_W-1:0]    LIMIT_RESET    = 10'd999;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_REPEAT_INTERVAL = 2'd0,
        REG_COUNT_LIMIT     = 2'd1
    } cfg_reg_t;

    function automatic logic [SEG_W-1:0] seg_of(input logic [3:0] d);
        logic [SEG_W-1:0] s;
        case (d)
            4'd0:    s = 7'h3f;
            4'd1:    s = 7'h06;
            4'd2:    s = 7'h5b;
            4'd3:    s = 7'h4f;
            4'd4:    s = 7'h66;
            4'd5:    s = 7'h6d;
            4'd6:    s = 7'h7d;
            4'd7:    s = 7'h07;
            4'd8:    s = 7'h7f;
            4'd9:    s = 7'h6f;
            default: s = 7'h00;
        endcase
        return s;
    endfunction

endpackage
`default_nettype wire

/* sv/arud_button.sv */
// Button press detect and auto-repeat countdown for one button.
`default_nettype none
module arud_button (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                en,
    input  wire logic                                pressed,
    input  wire logic [arud_pkg::INTERVAL_W-1:0]     interval,
    output logic                                     step
);

    logic                              held_reg, held_next;
    logic [arud_pkg::INTERVAL_W-1:0]   wait_reg, wait_next;
    logic [arud_pkg::INTERVAL_W-1:0]   wait_dec;

    assign wait_dec = (wait_reg != '0) ? wait_reg - 1'b1 : wait_reg;

    always_comb
    begin
        held_next = held_reg;
        wait_next = wait_reg;
        step      = 1'b0;
        if (!pressed)
        begin
            held_next = 1'b0;
        end
        else if (!held_reg)
        begin
            held_next = 1'b1;
            wait_next = interval;
            step      = 1'b1;
        end
        else if (wait_dec == '0)
        begin
            wait_next = interval;
            step      = 1'b1;
        end
        else
        begin
            wait_next = wait_dec;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg <= 1'b0;
            wait_reg <= '0;
        end
        else if (en)
        begin
            held_reg <= held_next;
            wait_reg <= wait_next;
        end
    end

endmodule
`default_nettype wire

/* sv/arud_digits.sv */
// Decimal digit splitter and result register, one digit per output transaction.
`default_nettype none
module arud_digits #(
    parameter int DIGITS = 3
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             load,
    input  wire logic [arud_pkg::COUNT_W-1:0]     count_in,
    output logic                                  can_load,
    output logic                                  out_valid,
    input  wire logic                             out_ready,
    output logic [arud_pkg::SEL_W-1:0]            digit_select,
    output logic [arud_pkg::SEG_W-1:0]            segments,
    output logic                                  digit_last,
    output logic [arud_pkg::COUNT_W-1:0]          count_value
);

    localparam int IDX_W = (DIGITS > 1) ? $clog2(DIGITS) : 1;
    localparam int CW    = arud_pkg::COUNT_W;

    logic                          valid_reg, valid_next;
    logic [IDX_W-1:0]              idx_reg, idx_next;
    logic [CW-1:0]                 rest_reg, rest_next;
    logic [arud_pkg::SEG_W-1:0]    seg_reg, seg_next;
    logic [CW-1:0]                 cval_reg, cval_next;

    logic                          last;
    logic                          take;
    logic [CW-1:0]                 src;
    logic [CW+10:0]                prod;
    logic [CW-1:0]                 quot;
    logic [CW-1:0]                 rem;

    assign last     = (idx_reg == IDX_W'(DIGITS - 1));
    assign take     = valid_reg && out_ready;
    assign can_load = !valid_reg || (out_ready && last);

    // x / 10 as (x * 205) >> 11, exact for every 10-bit x
    assign src  = load ? count_in : rest_reg;
    assign prod = (CW+11)'(src) * (CW+11)'(205);
    assign quot = prod[CW+10:11];
    assign rem  = src - CW'(quot * CW'(10));

    always_comb
    begin
        valid_next = valid_reg;
        idx_next   = idx_reg;
        rest_next  = rest_reg;
        seg_next   = seg_reg;
        cval_next  = cval_reg;
        if (load)
        begin
            valid_next = 1'b1;
            idx_next   = '0;
            rest_next  = quot;
            seg_next   = arud_pkg::seg_of(rem[3:0]);
            cval_next  = count_in;
        end
        else if (take && !last)
        begin
            idx_next   = idx_reg + IDX_W'(1);
            rest_next  = quot;
            seg_next   = arud_pkg::seg_of(rem[3:0]);
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rest_reg <= rest_next;
        seg_reg  <= seg_next;
        cval_reg <= cval_next;
    end

    assign out_valid    = valid_reg;
    assign digit_select = ~(arud_pkg::SEL_W'(1) << idx_reg);
    assign segments     = seg_reg;
    assign digit_last   = last;
    assign count_value  = cval_reg;

endmodule
`default_nettype wire

/* sv/auto_repeat_updown_counter_display.sv */
// Top level: auto-repeat up/down counter with a multiplexed seven-segment readout.
//
//  channel  | handshake            | payload
//  ---------+----------------------+----------------------------------------------
//  in       | in_valid / in_ready  | down_pressed, up_pressed
//  out      | out_valid/ out_ready | digit_select, segments, digit_last, count_value
//  cfg      | cfg_valid/ cfg_ready | cfg_index, cfg_data
//
// Each tick transaction yields DIGITS output transactions, units first, all
// from the single digit result register.
// The next tick is taken in the cycle the last digit leaves, so ticks stream back to back.
// Output stalls hold the result register and block new ticks.
// Reset clears count, button state and the result valid; config resets to 500 / 999.
`default_nettype none
module auto_repeat_updown_counter_display #(
    parameter int DIGITS = 3
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire logic                                down_pressed,
    input  wire logic                                up_pressed,
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic [arud_pkg::SEL_W-1:0]               digit_select,
    output logic [arud_pkg::SEG_W-1:0]               segments,
    output logic                                     digit_last,
    output logic [arud_pkg::COUNT_W-1:0]             count_value,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [arud_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [arud_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int CW = arud_pkg::COUNT_W;

    logic [arud_pkg::INTERVAL_W-1:0] interval_reg;
    logic [CW-1:0]                   limit_reg;
    logic [CW-1:0]                   count_reg, count_next;
    logic [CW-1:0]                   count_dn;
    logic [CW:0]                     count_up;
    logic                            accept;
    logic                            can_load;
    logic                            step_dn, step_up;

    assign cfg_ready = 1'b1;
    assign in_ready  = can_load;
    assign accept    = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            interval_reg <= arud_pkg::INTERVAL_RESET;
            limit_reg    <= arud_pkg::LIMIT_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                arud_pkg::REG_REPEAT_INTERVAL: interval_reg <= cfg_data;
                arud_pkg::REG_COUNT_LIMIT:     limit_reg    <= cfg_data[CW-1:0];
                default: ;
            endcase
        end
    end

    arud_button u_down (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (accept),
        .pressed  (down_pressed),
        .interval (interval_reg),
        .step     (step_dn)
    );

    arud_button u_up (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (accept),
        .pressed  (up_pressed),
        .interval (interval_reg),
        .step     (step_up)
    );

    // down before up, floor at zero, then clamp to the limit
    always_comb
    begin
        count_dn = (step_dn && count_reg != '0) ? count_reg - 1'b1 : count_reg;
        count_up = step_up ? {1'b0, count_dn} + 1'b1 : {1'b0, count_dn};
        if (count_up > {1'b0, limit_reg})
            count_next = limit_reg;
        else
            count_next = count_up[CW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else if (accept)
            count_reg <= count_next;
    end

    arud_digits #(
        .DIGITS (DIGITS)
    ) u_digits (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (accept),
        .count_in     (count_next),
        .can_load     (can_load),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .digit_select (digit_select),
        .segments     (segments),
        .digit_last   (digit_last),
        .count_value  (count_value)
    );

endmodule
`default_nettype wire
